### sv/bkl_pkg.sv
// Shared types and constants for the Bernoulli KL divergence block.
// No dependencies; used by the log unit, the sequencer and the top level.
package bkl_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam logic [27:0] LN2_Q28 = 28'd186065279;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_CBAD = 2'd2;
	localparam logic [1:0] ST_LEN = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_COMBINE,
		S_MUL,
		S_OUT
	} state_t;

endpackage

### sv/bernoulli_kl_sum_and_gradient_top.sv
// Top level of the Bernoulli KL divergence and gradient block.
// Depends on bkl_pkg and bkl_ln; up to four log evaluations per item, run in sequence.
// Only two run when x is 0 or 1 and none when c is 0. Items are handled one at a time:
// a new one is accepted after the last result is registered, which waits on m_tready.
// Reset clears sum, count, the sequencer and valid flags; vector_length resets to 64.
module bernoulli_kl_sum_and_gradient_top
	import bkl_pkg::*;
#(
	parameter int unsigned MAX_LENGTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // x_prob[16:0], c_prob[32:17], zero fill
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata, // kl_term[18:0], gradient[40:19], total_value[65:41], status[67:66]
	output logic        m_tlast
);

	localparam logic [16:0] ONE = 17'd65536;

	state_t             st_q, st_d;
	logic [1:0]         k_q;
	logic [6:0]         vlen_q, cnt_q;
	logic [24:0]        acc_q;
	logic [16:0]        x_q;
	logic [15:0]        c_q;
	logic               last_q;
	logic signed [40:0] ln_q [4];
	logic               ln_start, ln_done;
	logic [16:0]        ln_v;
	logic signed [40:0] ln_res;
	logic signed [41:0] d1_q, d2_q;
	logic signed [63:0] p1_q, p2_q;
	logic [18:0]        kl_q;
	logic [21:0]        gr_q;
	logic [1:0]         stat_q;
	logic [24:0]        tot_q;
	logic               mv_q, lo_q;
	logic [16:0]        xin;
	logic               cbad, xz, xo;
	logic signed [42:0] gsum;
	logic signed [42:0] gr_r;
	logic signed [64:0] ksum, kl_r;
	logic signed [40:0] kb_r;
	logic [25:0]        acc_n;
	logic [6:0]         cnt_n;
	logic               mism;

	assign xin = (s_tdata[16:0] > ONE) ? ONE : s_tdata[16:0];
	assign cbad = (c_q == 16'd0);
	assign xz = (x_q == 17'd0);
	assign xo = (x_q == ONE);

	always_comb begin
		case (k_q)
			2'd0: ln_v = {1'b0, c_q};
			2'd1: ln_v = ONE - {1'b0, c_q};
			2'd2: ln_v = x_q;
			default: ln_v = ONE - x_q;
		endcase
	end

	bkl_ln u_ln (
		.clk(clk), .arst_n(arst_n), .start(ln_start), .v(ln_v),
		.done(ln_done), .result(ln_res)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (s_tvalid) st_d = S_START;
			S_START: st_d = cbad ? S_MUL : S_WAIT;
			S_WAIT: begin
				if (ln_done) begin
					st_d = ((k_q == 2'd3) || (k_q == 2'd1 && (xz || xo))) ? S_COMBINE : S_START;
				end
			end
			S_COMBINE: st_d = S_MUL;
			S_MUL: if (!mv_q || m_tready) st_d = S_OUT;
			S_OUT: if (!mv_q || m_tready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		ln_start = (st_q == S_START) && !cbad;
		s_tready = (st_q == S_IDLE);
		cfg_ready = (st_q == S_IDLE) && !mv_q;
	end

	assign gsum = 43'(d1_q) - 43'(d2_q);
	assign gr_r = gsum[42] ? -((-gsum + 43'sd2048) >>> 12) : ((gsum + 43'sd2048) >>> 12);
	assign ksum = 65'(p1_q) + 65'(p2_q);
	assign kl_r = ksum[64] ? -((-ksum + 65'sd134217728) >>> 28)
		: ((ksum + 65'sd134217728) >>> 28);
	assign kb_r = ((xz ? -ln_q[1] : -ln_q[0]) + 41'sd2048) >>> 12;
	assign acc_n = {1'b0, acc_q} + {7'd0, kl_q};
	assign cnt_n = (cnt_q == 7'd127) ? cnt_q : cnt_q + 7'd1;
	assign mism = (vlen_q == 7'd0) || (32'(vlen_q) > MAX_LENGTH) || (cnt_n != vlen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q <= '0;
			vlen_q <= 7'd64;
			acc_q <= '0;
			cnt_q <= '0;
			mv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) vlen_q <= cfg_data;
			if (st_q == S_IDLE && s_tvalid) k_q <= '0;
			if (st_q == S_WAIT && ln_done) k_q <= k_q + 2'd1;
			if (st_q == S_OUT && (!mv_q || m_tready)) begin
				mv_q <= 1'b1;
				acc_q <= last_q ? '0 : (acc_n[25] ? '1 : acc_n[24:0]);
				cnt_q <= last_q ? '0 : cnt_n;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && s_tvalid) begin
			x_q <= xin;
			c_q <= s_tdata[32:17];
			last_q <= s_tlast;
		end
		if (st_q == S_WAIT && ln_done) ln_q[k_q] <= ln_res;
		if (st_q == S_COMBINE) begin
			d1_q <= 42'(ln_q[2]) - 42'(ln_q[0]);
			d2_q <= 42'(ln_q[3]) - 42'(ln_q[1]);
		end
		if (st_q == S_MUL && (!mv_q || m_tready)) begin
			if (cbad) begin
				kl_q <= '0; gr_q <= '0; stat_q <= ST_CBAD;
			end else if (xz || xo) begin
				kl_q <= (kb_r > 41'sd524287) ? '1 : kb_r[18:0];
				gr_q <= xz ? 22'h200000 : 22'h1FFFFF;
				stat_q <= ST_SAT;
			end else begin
				if (kl_r < 0) kl_q <= '0;
				else if (kl_r > 65'sd524287) kl_q <= '1;
				else kl_q <= kl_r[18:0];
				if (gr_r > 43'sd2097151) begin
					gr_q <= 22'h1FFFFF; stat_q <= ST_SAT;
				end else if (gr_r < -43'sd2097152) begin
					gr_q <= 22'h200000; stat_q <= ST_SAT;
				end else begin
					gr_q <= gr_r[21:0]; stat_q <= ST_OK;
				end
			end
		end
		if (st_q == S_OUT && (!mv_q || m_tready)) begin
			tot_q <= acc_n[25] ? '1 : acc_n[24:0];
			lo_q <= last_q;
			if (last_q && mism) stat_q <= ST_LEN;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_COMBINE) begin
			p1_q <= 64'($signed({1'b0, x_q})) * 64'(42'(ln_q[2]) - 42'(ln_q[0]));
			p2_q <= 64'($signed({1'b0, ONE - x_q})) * 64'(42'(ln_q[3]) - 42'(ln_q[1]));
		end
	end

	assign m_tvalid = mv_q;
	assign m_tlast = lo_q;
	assign m_tdata = {4'd0, stat_q, tot_q, gr_q, kl_q};

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> st_q == S_IDLE) else $error("ready outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(mv_q && !m_tready) |=> mv_q) else $error("result dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |-> acc_q == 25'd0) else $error("sum not cleared");

endmodule

### sv/bkl_ln.sv
// Shared iterative natural-log unit: ln(v / 2^FRAC_BITS) in signed Q.28.
// Depends on bkl_pkg. One squaring step per cycle, then a scaling multiply.
module bkl_ln
	import bkl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FRAC_BITS:0]   v,
	output logic                 done,
	output logic signed [40:0]   result
);

	localparam int unsigned EW = $clog2(FRAC_BITS + 2);

	typedef enum logic [1:0] {L_IDLE, L_SQ, L_SCALE, L_FIN} lstate_t;

	lstate_t            st_q;
	logic [4:0]         it_q;
	logic [31:0]        m_q;
	logic [27:0]        frac_q;
	logic [EW-1:0]      e_q;
	logic [63:0]        sq;
	logic [EW-1:0]      e_new;
	logic signed [40:0] l2;
	logic [40:0]        mag_q;
	logic               neg_q;
	logic [68:0]        prod_q;

	always_comb begin
		e_new = '0;
		for (int i = 0; i <= FRAC_BITS; i++) begin
			if (v[i]) begin
				e_new = EW'(i);
			end
		end
	end

	assign sq = m_q * m_q;
	assign l2 = ($signed({1'b0, 40'(e_q)}) - 41'(FRAC_BITS)) * 41'sd268435456
		+ $signed({13'd0, frac_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			done <= 1'b0;
		end else begin
			done <= (st_q == L_FIN);
			case (st_q)
				L_IDLE: begin
					if (start) begin
						st_q <= L_SQ;
					end
				end
				L_SQ: begin
					if (it_q == 5'd27) begin
						st_q <= L_SCALE;
					end
				end
				L_SCALE: st_q <= L_FIN;
				L_FIN: st_q <= L_IDLE;
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				if (start) begin
					e_q <= e_new;
					m_q <= 32'(({31'd0, v} << (30 - 32'(e_new))));
					frac_q <= '0;
					it_q <= '0;
				end
			end
			L_SQ: begin
				it_q <= it_q + 5'd1;
				if (sq[61]) begin
					m_q <= sq[62:31];
					frac_q[5'd27 - it_q] <= 1'b1;
				end else begin
					m_q <= sq[61:30];
				end
			end
			L_SCALE: begin
				neg_q <= l2[40];
				mag_q <= l2[40] ? 41'(-l2) : 41'(l2);
			end
			L_FIN: begin
				prod_q <= 69'(mag_q) * 69'(LN2_Q28) + 69'd134217728;
			end
			default: ;
		endcase
	end

	assign result = neg_q ? -$signed({1'b0, prod_q[67:28]}) : $signed({1'b0, prod_q[67:28]});

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for bernoulli_kl_sum_and_gradient_top: directed table, then random vectors.
// Depends on bkl_pkg and the top level; a fixed-point model predicts all but known table rows.
module tb_top;
	import bkl_pkg::*;

	typedef struct {
		logic [16:0] x;
		logic [15:0] c;
		logic        last;
	} elem_t;

	typedef struct {
		logic [18:0] kl;
		logic [21:0] grad;
		logic [24:0] total;
		logic        last;
		logic [1:0]  status;
	} kl_res_t;

	typedef struct {
		logic [16:0] x;
		logic [15:0] c;
		logic        last;
		logic        known;
		logic [18:0] kl;
		logic [21:0] grad;
		logic [1:0]  status;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;

	kl_res_t     expected_q[$];
	logic [6:0]  vec_len;
	logic [24:0] kl_sum;
	logic [6:0]  elem_cnt;
	int          errors;
	int          idle_cycles;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          done;

	bernoulli_kl_sum_and_gradient_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint rnd_shift(longint v, int s);
		longint half;
		half = 64'sd1 <<< (s - 1);
		if (v < 0)
			return -((-v + half) >>> s);
		return (v + half) >>> s;
	endfunction

	function automatic longint ln_q28(longint v);
		int e;
		longint t;
		longint unsigned m;
		longint frac;
		longint l2;
		longint unsigned a;
		e = 0;
		t = v;
		frac = 0;
		while (t > 1) begin
			t = t >> 1;
			e++;
		end
		m = v << (30 - e);
		for (int i = 0; i < 28; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | (64'sd1 << (27 - i));
			end
		end
		l2 = longint'(e - 16) * (64'sd1 << 28) + frac;
		a = (l2 < 0) ? -l2 : l2;
		a = (a * LN2_Q28 + (64'd1 << 27)) >> 28;
		return (l2 < 0) ? -longint'(a) : longint'(a);
	endfunction

	function automatic kl_res_t kl_predict(elem_t el);
		kl_res_t r;
		longint x, c, kl, grad, lc, l1c, d1, d2, acc;
		logic [1:0] st;
		logic [7:0] cnt;
		x = longint'(el.x);
		c = longint'(el.c);
		kl = 0;
		grad = 0;
		st = ST_OK;
		if (x > 65536)
			x = 65536;
		if (c == 0) begin
			st = ST_CBAD;
		end else begin
			lc = ln_q28(c);
			l1c = ln_q28(65536 - c);
			if (x == 0) begin
				kl = rnd_shift(-l1c, 12);
				grad = -2097152;
				st = ST_SAT;
			end else if (x == 65536) begin
				kl = rnd_shift(-lc, 12);
				grad = 2097151;
				st = ST_SAT;
			end else begin
				d1 = ln_q28(x) - lc;
				d2 = ln_q28(65536 - x) - l1c;
				kl = rnd_shift(x * d1 + (65536 - x) * d2, 28);
				grad = rnd_shift(d1 - d2, 12);
				if (grad > 2097151) begin
					grad = 2097151;
					st = ST_SAT;
				end
				if (grad < -2097152) begin
					grad = -2097152;
					st = ST_SAT;
				end
			end
			if (kl < 0)
				kl = 0;
			if (kl > 524287)
				kl = 524287;
		end
		acc = longint'(kl_sum) + kl;
		if (acc > 33554431)
			acc = 33554431;
		kl_sum = 25'(acc);
		cnt = 8'(elem_cnt) + 8'd1;
		if (cnt > 127)
			cnt = 127;
		elem_cnt = cnt[6:0];
		r.kl = 19'(kl);
		r.grad = 22'(grad);
		r.total = kl_sum;
		r.last = el.last;
		if (el.last) begin
			if (vec_len == 0 || vec_len > 64 || elem_cnt != vec_len)
				st = ST_LEN;
			kl_sum = 0;
			elem_cnt = 0;
		end
		r.status = st;
		return r;
	endfunction

	task automatic send_elem(elem_t el);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, el.c, el.x};
		s_tlast <= el.last;
		expected_q.push_back(kl_predict(el));
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_length(logic [6:0] len);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		vec_len = len;
	endtask

	task automatic send_vector(int n, bit sane);
		elem_t el;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: el.x = 17'd0;
				1: el.x = 17'($urandom_range(131071, 65536));
				2: el.x = 17'($urandom_range(20));
				3: el.x = 17'($urandom_range(65535, 65515));
				default: el.x = 17'($urandom_range(65536));
			endcase
			if (sane || $urandom_range(9) != 0)
				el.c = 16'($urandom_range(65535, 1));
			else
				el.c = $urandom_range(1) ? 16'd0 : 16'hffff;
			el.last = (i == n - 1) ? 1'b1 : (sane ? 1'b0 : ($urandom_range(19) == 0));
			send_elem(el);
		end
	endtask

	always @(posedge clk) begin
		kl_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kl = m_tdata[18:0];
			got.grad = m_tdata[40:19];
			got.total = m_tdata[65:41];
			got.status = m_tdata[67:66];
			got.last = m_tlast;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got != want) begin
					$display("%0t: expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000 && !done) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		elem_t el;
		kl_res_t pred;
		int sent;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		errors = 0;
		idle_cycles = 0;
		done = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		vec_len = 7'd64;
		kl_sum = 0;
		elem_cnt = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bad targets give all zeros; a lone last element mismatches the reset length.
		rows.push_back('{17'd100, 16'd0, 1'b0, 1'b1, 19'd0, 22'd0, ST_CBAD});
		rows.push_back('{17'h1ffff, 16'hffff, 1'b0, 1'b0, 0, 0, ST_OK});
		rows.push_back('{17'd32768, 16'd32768, 1'b0, 1'b1, 19'd0, 22'd0, ST_OK});
		rows.push_back('{17'd0, 16'd32768, 1'b0, 1'b0, 0, 0, ST_OK});
		rows.push_back('{17'd65536, 16'd1, 1'b0, 1'b0, 0, 0, ST_OK});
		rows.push_back('{17'h1ffff, 16'd65535, 1'b0, 1'b0, 0, 0, ST_OK});
		rows.push_back('{17'd1, 16'd65535, 1'b0, 1'b0, 0, 0, ST_OK});
		rows.push_back('{17'd65535, 16'd1, 1'b0, 1'b0, 0, 0, ST_OK});
		rows.push_back('{17'd0, 16'd1, 1'b0, 1'b0, 0, 0, ST_OK});
		rows.push_back('{17'd21845, 16'd43690, 1'b1, 1'b0, 0, 0, ST_OK});
		rows.push_back('{17'd40000, 16'd40000, 1'b1, 1'b1, 19'd0, 22'd0, ST_LEN});
		foreach (rows[i]) begin
			rw = rows[i];
			el = '{rw.x, rw.c, rw.last};
			if (rw.known) begin
				pred = kl_predict(el);
				kl_sum = kl_sum - 25'(pred.kl);
				elem_cnt = 7'(elem_cnt - 7'd1);
				if (rw.last) begin
					kl_sum = 0;
					elem_cnt = 0;
				end
			end
			send_elem(el);
			if (rw.known) begin
				pred = expected_q[$];
				pred.kl = rw.kl;
				pred.grad = rw.grad;
				pred.status = rw.status;
				expected_q[$] = pred;
			end
		end

		write_length(7'd1);
		send_vector(1, 1);
		send_vector(2, 1);
		write_length(7'd0);
		send_vector(1, 1);
		write_length(7'd127);
		send_vector(3, 1);
		write_length(7'd64);
		send_vector(64, 1);
		send_vector(63, 1);
		write_length(7'd65);
		send_vector(65, 1);
		for (int i = 0; i < 130; i++) begin
			el = '{17'd65536, 16'd1, 1'b0};
			send_elem(el);
		end
		send_vector(1, 1);

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			write_length($urandom_range(1) ? 7'($urandom_range(12, 1)) : 7'($urandom_range(127)));
			sent = 0;
			while (sent < 360) begin
				int n;
				n = ($urandom_range(3) == 0) ? $urandom_range(16, 1) : vec_len;
				if (n == 0 || n > 64)
					n = $urandom_range(8, 1);
				if ($urandom_range(7) == 0)
					n = n + 1;
				send_vector(n, $urandom_range(4) != 0);
				sent += n;
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		done = 1;
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
